/* design/srsw_pkg.sv */
package srsw_pkg;

    // default sizes
    localparam int SEQ_COUNT_DEF  = 20;
    localparam int COUNT_BITS_DEF = 16;

    // configuration field widths and reset values
    localparam int WINDOW_W = 5;
    localparam int TOTAL_W  = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd10;
    localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 16'd24;

    // register indexes on the apb port
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_TOTAL  = 1'b1;

    // request kinds
    typedef enum logic [1:0] {
        REQ_SEND    = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    // operations of the shared sequence unit
    typedef enum logic {
        OP_DIST = 1'b0,
        OP_INC  = 1'b1
    } seq_op_t;

    // control word for the shared unit
    typedef struct packed {
        seq_op_t op;
    } seq_ctrl_t;

endpackage

/* design/selective_repeat_send_window_top.sv */
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   req_type, ack_number
// out       output     out_valid / out_stall send_valid, send_seq, packet_index,
//                                            transfer_done, window_base, in_flight
// apb       input      psel/penable/pready   paddr, pwdata, prdata
//
// a request passes through the eval, decide and final states; an ack that lands in the window
// also passes through the slide state, where the shared sequence unit steps the base over the
// acknowledged entries and stops at next
// in_stall is high from the cycle after a transfer until the result is loaded
// a finished result waits in the output register while the next request is taken
// rst_n clears the window state and restores the register defaults asynchronously
module selective_repeat_send_window_top
    import srsw_pkg::*;
#(
    parameter int SEQ_COUNT  = SEQ_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int SEQ_BITS  = $clog2(SEQ_COUNT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [7:0]            ack_number,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  send_valid,
    output logic [SEQ_BITS-1:0]   send_seq,
    output logic [COUNT_BITS-1:0] packet_index,
    output logic                  transfer_done,
    output logic [SEQ_BITS-1:0]   window_base,
    output logic [SEQ_BITS-1:0]   in_flight,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_SLIDE,
        S_FINAL
    } state_t;

    state_t                state_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [SEQ_COUNT-1:0]  acked_reg;
    logic [SEQ_BITS-1:0]   base_reg;
    logic [SEQ_BITS-1:0]   next_reg;
    logic [COUNT_BITS-1:0] issued_reg;
    logic [SEQ_BITS-1:0]   outstanding_reg;
    req_t                  req_reg;
    logic [7:0]            ack_reg;
    logic                  res_valid_reg;
    logic [SEQ_BITS-1:0]   res_seq_reg;
    logic [COUNT_BITS-1:0] res_idx_reg;
    logic                  out_valid_reg;
    logic                  send_valid_reg;
    logic [SEQ_BITS-1:0]   send_seq_reg;
    logic [COUNT_BITS-1:0] packet_index_reg;
    logic                  transfer_done_reg;
    logic [SEQ_BITS-1:0]   window_base_reg;
    logic [SEQ_BITS-1:0]   in_flight_reg;

    seq_ctrl_t             unit_ctrl;
    logic [SEQ_BITS-1:0]   unit_a;
    logic [SEQ_BITS-1:0]   unit_b;
    logic [SEQ_BITS-1:0]   unit_res;
    logic [SEQ_BITS-1:0]   rd_addr;
    logic                  map_bit;
    logic [7:0]            ack_idx;
    logic                  ack_in_range;
    logic [31:0]           eff_window;
    logic                  send_ok;
    logic                  out_free;
    logic                  cfg_write;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_TOTAL) ? 32'(total_reg) : 32'(window_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            total_reg  <= TOTAL_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WINDOW)
            begin
                window_reg <= pwdata[WINDOW_W-1:0];
            end
            else
            begin
                total_reg <= pwdata[TOTAL_W-1:0];
            end
        end
    end

    // ack decode and send admission
    assign ack_idx      = ack_reg - 8'd1;
    assign ack_in_range = (32'(ack_idx) < 32'(SEQ_COUNT));
    assign eff_window   = (32'(window_reg) >= 32'(SEQ_COUNT)) ? 32'(SEQ_COUNT - 1)
                                                              : 32'(window_reg);
    assign rd_addr      = (state_reg == S_SLIDE) ? base_reg : next_reg;
    assign map_bit      = acked_reg[rd_addr];
    assign send_ok      = (32'(issued_reg) < 32'(total_reg)) && (issued_reg != '1) &&
                          (32'(outstanding_reg) < eff_window) && map_bit;

    // operand select for the shared unit
    always_comb
    begin
        unit_ctrl.op = OP_DIST;
        unit_a       = base_reg;
        unit_b       = next_reg;
        case (state_reg)
            S_DECIDE:
            begin
                if (req_reg == REQ_ACK)
                begin
                    unit_b = ack_idx[SEQ_BITS-1:0];
                end
                else
                begin
                    unit_ctrl.op = OP_INC;
                    unit_a       = next_reg;
                end
            end
            S_SLIDE:
            begin
                unit_ctrl.op = OP_INC;
            end
            default:
            begin
                unit_ctrl.op = OP_DIST;
            end
        endcase
    end

    srsw_seq_unit #(
        .SEQ_COUNT (SEQ_COUNT)
    ) u_seq_unit (
        .ctrl   (unit_ctrl),
        .a      (unit_a),
        .b      (unit_b),
        .result (unit_res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            acked_reg         <= '1;
            base_reg          <= '0;
            next_reg          <= '0;
            issued_reg        <= '0;
            out_valid_reg     <= 1'b0;
            outstanding_reg   <= '0;
            req_reg           <= REQ_SEND;
            ack_reg           <= '0;
            res_valid_reg     <= 1'b0;
            res_seq_reg       <= '0;
            res_idx_reg       <= '0;
            send_valid_reg    <= 1'b0;
            send_seq_reg      <= '0;
            packet_index_reg  <= '0;
            transfer_done_reg <= 1'b0;
            window_base_reg   <= '0;
            in_flight_reg     <= '0;
        end
        else
        begin
            // result leaves on a transfer, unless a new one is loaded behind it
            if (out_valid_reg && !out_stall && (state_reg != S_FINAL))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= req_t'(req_type);
                        ack_reg   <= ack_number;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    outstanding_reg <= unit_res;
                    res_valid_reg   <= 1'b0;
                    res_seq_reg     <= '0;
                    res_idx_reg     <= '0;
                    state_reg       <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_FINAL;
                    case (req_reg)
                        REQ_SEND:
                        begin
                            if (send_ok)
                            begin
                                res_valid_reg       <= 1'b1;
                                res_seq_reg         <= next_reg;
                                res_idx_reg         <= issued_reg;
                                acked_reg[next_reg] <= 1'b0;
                                next_reg            <= unit_res;
                                issued_reg          <= issued_reg + 1'b1;
                            end
                        end
                        REQ_ACK:
                        begin
                            if (ack_in_range && (unit_res < outstanding_reg))
                            begin
                                acked_reg[ack_idx[SEQ_BITS-1:0]] <= 1'b1;
                                state_reg <= S_SLIDE;
                            end
                        end
                        REQ_TIMEOUT:
                        begin
                            if (outstanding_reg != '0)
                            begin
                                res_valid_reg       <= 1'b1;
                                res_seq_reg         <= base_reg;
                                res_idx_reg         <= issued_reg -
                                                       COUNT_BITS'(outstanding_reg);
                                acked_reg[base_reg] <= 1'b0;
                            end
                        end
                        default:
                        begin
                            acked_reg  <= '1;
                            base_reg   <= '0;
                            next_reg   <= '0;
                            issued_reg <= '0;
                        end
                    endcase
                end
                S_SLIDE:
                begin
                    // step the base over acknowledged entries, stop at next
                    if ((base_reg != next_reg) && map_bit)
                    begin
                        base_reg <= unit_res;
                    end
                    else
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        send_valid_reg    <= res_valid_reg;
                        send_seq_reg      <= res_seq_reg;
                        packet_index_reg  <= res_idx_reg;
                        transfer_done_reg <= (32'(issued_reg) >= 32'(total_reg));
                        window_base_reg   <= base_reg;
                        in_flight_reg     <= unit_res;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = send_valid_reg;
    assign send_seq      = send_seq_reg;
    assign packet_index  = packet_index_reg;
    assign transfer_done = transfer_done_reg;
    assign window_base   = window_base_reg;
    assign in_flight     = in_flight_reg;

`ifndef SYNTHESIS
    // sequence pointers stay inside the sequence space
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(base_reg) < 32'(SEQ_COUNT)) && (32'(next_reg) < 32'(SEQ_COUNT)))
        else $error("sequence pointer out of range");

    // an accepted request starts evaluation next cycle
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EVAL))
        else $error("accepted request not evaluated");

    // the slide never moves the base once it meets next
    a_slide_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLIDE && base_reg == next_reg) |=> (base_reg == $past(base_reg)))
        else $error("base slid past next");

    // a finished request with a free output register is delivered
    a_final_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");
`endif

endmodule

/* design/srsw_seq_unit.sv */
module srsw_seq_unit
    import srsw_pkg::*;
#(
    parameter int SEQ_COUNT = SEQ_COUNT_DEF,
    localparam int SEQ_BITS = $clog2(SEQ_COUNT)
) (
    input  seq_ctrl_t           ctrl,
    input  logic [SEQ_BITS-1:0] a,
    input  logic [SEQ_BITS-1:0] b,
    output logic [SEQ_BITS-1:0] result
);

    localparam logic [SEQ_BITS:0] MODULUS = (SEQ_BITS+1)'(SEQ_COUNT);

    logic [SEQ_BITS:0] a_ext;
    logic [SEQ_BITS:0] b_ext;
    logic [SEQ_BITS:0] inc_sum;
    logic [SEQ_BITS:0] dist_val;

    assign a_ext   = {1'b0, a};
    assign b_ext   = {1'b0, b};
    assign inc_sum = a_ext + 1'b1;

    // circular distance from a to b
    assign dist_val = (b_ext >= a_ext) ? (b_ext - a_ext) : (b_ext + MODULUS - a_ext);

    // one operation per cycle, picked by the sequencer
    always_comb
    begin
        case (ctrl.op)
            OP_INC:  result = (inc_sum >= MODULUS) ? '0 : inc_sum[SEQ_BITS-1:0];
            OP_DIST: result = dist_val[SEQ_BITS-1:0];
            default: result = dist_val[SEQ_BITS-1:0];
        endcase
    end

endmodule

/* test/srsw_checker.sv */
`timescale 1ns / 100ps

module srsw_window_checker
    import srsw_pkg::*;
#(
    parameter int SEQ_COUNT  = SEQ_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int SEQ_BITS  = $clog2(SEQ_COUNT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [7:0]            ack_number,
    // result channel
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  send_valid,
    input  logic [SEQ_BITS-1:0]   send_seq,
    input  logic [COUNT_BITS-1:0] packet_index,
    input  logic                  transfer_done,
    input  logic [SEQ_BITS-1:0]   window_base,
    input  logic [SEQ_BITS-1:0]   in_flight,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    // status to the testbench top
    output int                    results_owed,
    output int                    mismatch_count
);

    typedef struct packed {
        logic                  send_valid;
        logic [SEQ_BITS-1:0]   send_seq;
        logic [COUNT_BITS-1:0] packet_index;
        logic                  transfer_done;
        logic [SEQ_BITS-1:0]   window_base;
        logic [SEQ_BITS-1:0]   in_flight;
    } window_result_t;

    // shadow of the sender window and its registers
    logic [SEQ_COUNT-1:0]  free_map;
    logic [SEQ_BITS-1:0]   base_seq;
    logic [SEQ_BITS-1:0]   next_seq;
    logic [COUNT_BITS-1:0] issued;
    logic [WINDOW_W-1:0]   window_cfg;
    logic [TOTAL_W-1:0]    total_cfg;

    window_result_t expected_results[$];
    window_result_t predicted;
    window_result_t oldest;

    // circular distance from one sequence number to another
    function automatic int seq_gap(int from, int to);
        return (to >= from) ? to - from : to + SEQ_COUNT - from;
    endfunction

    function automatic logic [SEQ_BITS-1:0] seq_after(logic [SEQ_BITS-1:0] s);
        return (s == SEQ_COUNT - 1) ? '0 : s + 1'b1;
    endfunction

    // apply one request to the shadow window and form its result
    task automatic advance_sender(input req_t kind, input logic [7:0] wire_ack,
                                  output window_result_t res);
        int outstanding;
        int span;
        logic [7:0] ack_seq;
        res = '0;
        outstanding = seq_gap(base_seq, next_seq);
        span = (window_cfg >= SEQ_COUNT) ? SEQ_COUNT - 1 : window_cfg;
        case (kind)
            REQ_SEND:
            begin
                if (issued < total_cfg && issued != '1 && outstanding < span &&
                    free_map[next_seq])
                begin
                    res.send_valid   = 1'b1;
                    res.send_seq     = next_seq;
                    res.packet_index = issued;
                    free_map[next_seq] = 1'b0;
                    next_seq = seq_after(next_seq);
                    issued = issued + 1'b1;
                end
            end
            REQ_ACK:
            begin
                // wire byte carries sequence plus one
                ack_seq = wire_ack - 8'd1;
                if (ack_seq < SEQ_COUNT && seq_gap(base_seq, ack_seq) < outstanding)
                begin
                    free_map[ack_seq] = 1'b1;
                    while (base_seq != next_seq && free_map[base_seq])
                        base_seq = seq_after(base_seq);
                end
            end
            REQ_TIMEOUT:
            begin
                if (outstanding > 0)
                begin
                    res.send_valid   = 1'b1;
                    res.send_seq     = base_seq;
                    res.packet_index = COUNT_BITS'(issued - outstanding);
                    free_map[base_seq] = 1'b0;
                end
            end
            default:
            begin
                free_map = '1;
                base_seq = '0;
                next_seq = '0;
                issued   = '0;
            end
        endcase
        res.transfer_done = (issued >= total_cfg);
        res.window_base   = base_seq;
        res.in_flight     = SEQ_BITS'(seq_gap(base_seq, next_seq));
    endtask

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map   = '1;
            base_seq   = '0;
            next_seq   = '0;
            issued     = '0;
            window_cfg = WINDOW_RESET;
            total_cfg  = TOTAL_RESET;
            expected_results.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end
        else
        begin
            // register write on the apb port
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WINDOW)
                    window_cfg = pwdata[WINDOW_W-1:0];
                else
                    total_cfg = pwdata[TOTAL_W-1:0];
            end
            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, send_seq %0d packet_index %0d",
                             $time, send_seq, packet_index);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("send_valid", oldest.send_valid, send_valid);
                    check_field("send_seq", oldest.send_seq, send_seq);
                    check_field("packet_index", oldest.packet_index, packet_index);
                    check_field("transfer_done", oldest.transfer_done, transfer_done);
                    check_field("window_base", oldest.window_base, window_base);
                    check_field("in_flight", oldest.in_flight, in_flight);
                end
            end
            // request transfer
            if (in_valid && !in_stall)
            begin
                advance_sender(req_t'(req_type), ack_number, predicted);
                expected_results.push_back(predicted);
            end
            results_owed <= expected_results.size();
        end
    end

endmodule

/* test/tb_selective_repeat_send_window_top.sv */
`timescale 1ns / 100ps

module tb_selective_repeat_send_window_top;
    import srsw_pkg::*;

    localparam int SEQ_COUNT    = SEQ_COUNT_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int SEQ_BITS     = $clog2(SEQ_COUNT);
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_PHASE   = 1;
    localparam int CALM_PHASE   = 3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            req_type;
    logic [7:0]            ack_number;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  send_valid;
    logic [SEQ_BITS-1:0]   send_seq;
    logic [COUNT_BITS-1:0] packet_index;
    logic                  transfer_done;
    logic [SEQ_BITS-1:0]   window_base;
    logic [SEQ_BITS-1:0]   in_flight;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int results_owed;
    int mismatch_count;
    int cycle_count = 0;
    logic calm;
    logic hold_arm;
    int hold_left = 0;
    bit hold_used = 1'b0;

    // window and transfer length per random phase
    int window_plan [PHASES] = '{1, 19, 0, 31, 5, 19, 7, 12};
    int total_plan  [PHASES] = '{5, 40, 8, 30, 0, 65535, 1, 100};

    always #4 clk = ~clk;

    selective_repeat_send_window_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .ack_number    (ack_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .send_valid    (send_valid),
        .send_seq      (send_seq),
        .packet_index  (packet_index),
        .transfer_done (transfer_done),
        .window_base   (window_base),
        .in_flight     (in_flight),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    srsw_window_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .ack_number     (ack_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_valid     (send_valid),
        .send_seq       (send_seq),
        .packet_index   (packet_index),
        .transfer_done  (transfer_done),
        .window_base    (window_base),
        .in_flight      (in_flight),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    // result side: random stalls, one long hold-off, none in the calm phase
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 36);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_selective_repeat_send_window_top: done, errors");
            $finish;
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic push_request(input req_t kind, input logic [7:0] wire_ack);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        ack_number <= wire_ack;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drain every outstanding result before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int pick;
        logic [7:0] wire_ack;
        in_valid   <= 1'b0;
        req_type   <= REQ_SEND;
        ack_number <= 8'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;
        calm       <= 1'b0;
        hold_arm   <= 1'b0;
        rst_n      <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset registers
        push_request(REQ_SEND, 8'd0);
        push_request(REQ_SEND, 8'd0);
        // ack of the second packet first, then out of range acks
        push_request(REQ_ACK, 8'd2);
        push_request(REQ_ACK, 8'd0);
        push_request(REQ_ACK, 8'(SEQ_COUNT + 1));
        // ack of the base slides over both
        push_request(REQ_ACK, 8'd1);
        // timeout with nothing outstanding
        push_request(REQ_TIMEOUT, 8'd0);
        push_request(REQ_SEND, 8'd0);
        push_request(REQ_SEND, 8'd0);
        push_request(REQ_SEND, 8'd0);
        push_request(REQ_TIMEOUT, 8'hff);
        // ack outside the window, then one inside but not at the base
        push_request(REQ_ACK, 8'(SEQ_COUNT));
        push_request(REQ_ACK, 8'd4);
        push_request(REQ_RESTART, 8'hff);
        // fill the window and try one past it
        repeat (11) push_request(REQ_SEND, 8'd0);
        settle();

        // random phases over several register settings
        for (int p = 0; p < PHASES; p++)
        begin
            apb_write({REG_WINDOW, 2'b00}, 32'(window_plan[p]));
            apb_write({REG_TOTAL, 2'b00}, 32'(total_plan[p]));
            calm     <= (p == CALM_PHASE);
            hold_arm <= (p == HOLD_PHASE);
            @(posedge clk);
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                wire_ack = 8'($urandom_range(0, 255));
                if (pick < 42)
                    push_request(REQ_SEND, wire_ack);
                else if (pick < 80)
                begin
                    // mostly acks that name a real sequence number
                    if ($urandom_range(0, 9) != 0)
                        wire_ack = 8'($urandom_range(1, SEQ_COUNT));
                    push_request(REQ_ACK, wire_ack);
                end
                else if (pick < 96)
                    push_request(REQ_TIMEOUT, wire_ack);
                else
                    push_request(REQ_RESTART, wire_ack);
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("tb_selective_repeat_send_window_top: done, clean");
        else
            $display("tb_selective_repeat_send_window_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/srsw_pkg.sv
design/srsw_seq_unit.sv
design/selective_repeat_send_window_top.sv
test/srsw_checker.sv
test/tb_selective_repeat_send_window_top.sv
